// ===== hw/rtl/kvat_pkg.sv =====
package kvat_pkg;

   // parser position between tokens
   typedef enum logic [2:0] {
      POS_BEFORE_KEY   = 3'd0,
      POS_IN_KEY       = 3'd1,
      POS_AFTER_KEY    = 3'd2,
      POS_BEFORE_VALUE = 3'd3,
      POS_IN_VALUE     = 3'd4
   } pos_type;

   // action returned for each item
   typedef enum logic [1:0] {
      ACT_DROP   = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_KEY    = 2'd2,
      ACT_VALUE  = 2'd3
   } act_type;

   // item kind carried in req_tuser
   typedef enum logic {
      KIND_BYTE = 1'b0,
      KIND_END  = 1'b1
   } kind_type;

   localparam logic [7:0] TAG_RESET = 8'h3D;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_FIRST  = 8'h20;
   localparam logic [7:0] CH_LAST   = 8'h7E;

   // parser state carried from item to item
   typedef struct packed {
      pos_type pos;
      logic    squote_open;
      logic    dquote_open;
   } parse_state_type;

   // one result item
   typedef struct packed {
      act_type    act;
      logic [7:0] ch;
   } result_type;

endpackage

// ===== hw/rtl/kvat_parse.sv =====
module kvat_parse (
   input  kvat_pkg::kind_type        kind,
   input  logic [7:0]                char_in,
   input  logic [7:0]                tag_char,
   input  kvat_pkg::parse_state_type state_cur,
   output kvat_pkg::parse_state_type state_next,
   output kvat_pkg::result_type      result
);

   kvat_pkg::act_type act;
   logic              any_quote;

   assign any_quote = state_cur.squote_open | state_cur.dquote_open;

   // classify the byte and update position and quote flags
   always_comb begin
      state_next = state_cur;
      act        = kvat_pkg::ACT_DROP;
      priority if (kind == kvat_pkg::KIND_END) begin
         state_next.pos         = kvat_pkg::POS_BEFORE_KEY;
         state_next.squote_open = 1'b0;
         state_next.dquote_open = 1'b0;
         act                    = kvat_pkg::ACT_VALUE;
      end else if (!any_quote && char_in == tag_char) begin
         state_next.pos = kvat_pkg::POS_BEFORE_VALUE;
         act            = kvat_pkg::ACT_KEY;
      end else if (char_in < kvat_pkg::CH_FIRST || char_in > kvat_pkg::CH_LAST) begin
         act = kvat_pkg::ACT_DROP;
      end else if (char_in == kvat_pkg::CH_SPACE) begin
         if (state_cur.pos == kvat_pkg::POS_IN_KEY) begin
            state_next.pos = kvat_pkg::POS_AFTER_KEY;
         end else if (state_cur.pos == kvat_pkg::POS_IN_VALUE) begin
            state_next.pos = kvat_pkg::POS_BEFORE_KEY;
         end
      end else if (char_in == kvat_pkg::CH_SQUOTE) begin
         if (!state_cur.squote_open) begin
            if (state_cur.pos == kvat_pkg::POS_IN_VALUE) begin
               act = kvat_pkg::ACT_APPEND;
            end
            state_next.squote_open = 1'b1;
         end else begin
            if (state_cur.dquote_open) begin
               act = kvat_pkg::ACT_APPEND;
            end
            state_next.squote_open = 1'b0;
         end
      end else if (char_in == kvat_pkg::CH_DQUOTE) begin
         if (!state_cur.dquote_open) begin
            if (state_cur.pos == kvat_pkg::POS_IN_VALUE) begin
               act = kvat_pkg::ACT_APPEND;
            end
            state_next.dquote_open = 1'b1;
         end else begin
            if (state_cur.squote_open) begin
               act = kvat_pkg::ACT_APPEND;
            end
            state_next.dquote_open = 1'b0;
         end
      end else if (char_in == kvat_pkg::CH_COMMA) begin
         if (state_cur.pos == kvat_pkg::POS_IN_VALUE && any_quote) begin
            act = kvat_pkg::ACT_APPEND;
         end else begin
            act            = kvat_pkg::ACT_VALUE;
            state_next.pos = kvat_pkg::POS_BEFORE_KEY;
         end
      end else begin
         act = kvat_pkg::ACT_APPEND;
         if (state_cur.pos == kvat_pkg::POS_BEFORE_KEY) begin
            state_next.pos = kvat_pkg::POS_IN_KEY;
         end else if (state_cur.pos == kvat_pkg::POS_BEFORE_VALUE) begin
            state_next.pos = kvat_pkg::POS_IN_VALUE;
         end
      end
   end

   // echo the byte only on append
   assign result.act = act;
   assign result.ch  = (act == kvat_pkg::ACT_APPEND) ? char_in : 8'h00;

endmodule

// ===== hw/rtl/key_value_attribute_tokenizer.sv =====
// Attribute-string tokenizer: one byte item in, one action item out, one item per
// cycle sustained while rsp_tready is high. An item is held in the input register,
// is classified there against the parser state and the tag byte, and moves to the
// output register when that register is empty or being read; rsp_tvalid rises once
// the item lands there. The parser state advances as each item moves into the
// output register, which is the only loop in the design.
// The input side keeps accepting while a result waits, up to one item held in each
// register. Write csr only while no item is in flight.
module key_value_attribute_tokenizer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_in
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] char_out
   output logic [1:0] rsp_tuser,   // [1:0] action
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data
);

   logic                      s0_valid_ff, s0_valid_in;
   kvat_pkg::kind_type        s0_kind_ff;
   logic [7:0]                s0_char_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   kvat_pkg::result_type      rsp_ff;
   kvat_pkg::parse_state_type state_ff, state_in;
   logic [7:0]                tag_ff;
   kvat_pkg::result_type      result;
   logic                      s0_move;
   logic                      req_take;

   // handshake between the two registers
   assign s0_move      = s0_valid_ff & (~rsp_valid_ff | rsp_tready);
   assign req_tready   = ~s0_valid_ff | s0_move;
   assign req_take     = req_tvalid & req_tready;
   assign s0_valid_in  = req_take | (s0_valid_ff & ~s0_move);
   assign rsp_valid_in = s0_move | (rsp_valid_ff & ~rsp_tready);

   // per-byte classification
   kvat_parse u_parse (
      .kind       (s0_kind_ff),
      .char_in    (s0_char_ff),
      .tag_char   (tag_ff),
      .state_cur  (state_ff),
      .state_next (state_in),
      .result     (result)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         tag_ff       <= kvat_pkg::TAG_RESET;
         state_ff     <= '{pos: kvat_pkg::POS_BEFORE_KEY, squote_open: 1'b0,
                           dquote_open: 1'b0};
      end else begin
         s0_valid_ff  <= s0_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            tag_ff <= csr_wr_data;
         end
         if (s0_move) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s0_kind_ff <= kvat_pkg::kind_type'(req_tuser);
         s0_char_ff <= req_tdata;
      end
      if (s0_move) begin
         rsp_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.ch;
   assign rsp_tuser  = rsp_ff.act;

   // end of string leaves the parser at its start
   a_end_clears : assert property (@(posedge clock) disable iff (reset)
      (s0_move && s0_kind_ff == kvat_pkg::KIND_END) |=>
      (state_ff.pos == kvat_pkg::POS_BEFORE_KEY && !state_ff.squote_open &&
       !state_ff.dquote_open))
      else $error("parser state not cleared after end of string");

   // a moved item always shows up as a result
   a_move_shows : assert property (@(posedge clock) disable iff (reset)
      s0_move |=> rsp_tvalid)
      else $error("item moved but no result valid");

   // byte echoed only on append
   a_echo_append : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser != kvat_pkg::ACT_APPEND) |-> rsp_tdata == 8'h00)
      else $error("char_out nonzero without append");

   // the parser state only changes when an item moves
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !s0_move |=> $stable(state_ff))
      else $error("parser state changed without an item");

endmodule
